@@ src/wavhp_pkg.sv @@
// Types and constants for the WAV ADPCM header parser.
// Holds the parse phase enum, status codes and the marker byte lookup.
// No dependencies.
package wavhp_pkg;

    typedef enum logic [3:0] {
        PH_RIFF     = 4'd0,
        PH_RIFFSIZE = 4'd1,
        PH_WAVE     = 4'd2,
        PH_SCANFMT  = 4'd3,
        PH_FMTSIZE  = 4'd4,
        PH_FMTTAG   = 4'd5,
        PH_CHAN     = 4'd6,
        PH_RATE     = 4'd7,
        PH_SKIP     = 4'd8,
        PH_ALIGN    = 4'd9,
        PH_SCANDATA = 4'd10,
        PH_SIZE     = 4'd11,
        PH_DONE     = 4'd12
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_RIFF = 3'd1,
        ST_NOT_ADPCM = 3'd2,
        ST_NOT_MONO = 3'd3,
        ST_NO_DATA  = 3'd4
    } status_t;

    localparam logic [7:0] FMT_ADPCM_LO = 8'h11;
    localparam logic [7:0] CHAN_MONO_LO = 8'h01;
    localparam logic [7:0] CODE_HI      = 8'h00;

    function automatic logic [7:0] riff_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h52;
            2'd1:    r = 8'h49;
            default: r = 8'h46;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] wave_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h57;
            2'd1:    r = 8'h41;
            2'd2:    r = 8'h56;
            default: r = 8'h45;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] fmt_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h66;
            2'd1:    r = 8'h6d;
            2'd2:    r = 8'h74;
            default: r = 8'h20;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] data_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h64;
            2'd1:    r = 8'h61;
            2'd2:    r = 8'h74;
            default: r = 8'h61;
        endcase
        return r;
    endfunction

endpackage

@@ src/wav_adpcm_header_parser_unit.sv @@
// WAV ADPCM header parser: scans a RIFF/WAVE byte stream and reports the header.
// A result is registered and becomes valid in the cycle after the beat that completes or fails it.
// Throughput: one byte beat per cycle while m_ready is high; a result held by low
// m_ready stalls the input until it is taken.
// Reset (aresetn low, synchronous): parse restarts at the RIFF tag, pending result dropped.
// Depends on wavhp_pkg.
module wav_adpcm_header_parser_unit
    import wavhp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_first_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_sample_rate,
    output logic [15:0] m_block_align,
    output logic [31:0] m_data_size
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  match_reg, match_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] align_reg, align_next;
    logic [31:0] size_reg, size_next;

    logic        m_valid_reg;
    status_t     status_reg;
    logic [31:0] out_rate_reg;
    logic [15:0] out_align_reg;
    logic [31:0] out_size_reg;

    logic        accept;
    logic        emit;
    status_t     st;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        phase_t      ph;
        logic [1:0]  cnt;
        logic [1:0]  mm;
        logic [7:0]  b;
        logic        fail;
        b    = s_byte_value;
        ph   = phase_reg;
        cnt  = cnt_reg;
        mm   = match_reg;
        rate_next  = rate_reg;
        align_next = align_reg;
        size_next  = size_reg;
        fail = 1'b0;
        emit = 1'b0;
        st   = ST_OK;
        if (s_first_byte) begin
            ph  = PH_RIFF;
            cnt = 2'd0;
            mm  = 2'd0;
            rate_next  = '0;
            align_next = '0;
            size_next  = '0;
        end
        phase_next = ph;
        cnt_next   = cnt + 2'd1;
        match_next = mm;
        case (ph)
            PH_RIFF: begin
                if (b != riff_byte(cnt)) begin
                    fail = 1'b1;
                    st   = ST_BAD_RIFF;
                end else if (cnt == 2'd3) begin
                    phase_next = PH_RIFFSIZE;
                end
            end
            PH_RIFFSIZE: begin
                if (cnt == 2'd3) phase_next = PH_WAVE;
            end
            PH_WAVE: begin
                if (b != wave_byte(cnt)) begin
                    fail = 1'b1;
                    st   = ST_BAD_RIFF;
                end else if (cnt == 2'd3) begin
                    phase_next = PH_SCANFMT;
                end
            end
            PH_SCANFMT: begin
                cnt_next = cnt;
                if (b == fmt_byte(mm)) begin
                    match_next = mm + 2'd1;
                    if (mm == 2'd3) phase_next = PH_FMTSIZE;
                end else begin
                    match_next = (b == fmt_byte(2'd0)) ? 2'd1 : 2'd0;
                end
            end
            PH_FMTSIZE: begin
                if (cnt == 2'd3) phase_next = PH_FMTTAG;
            end
            PH_FMTTAG: begin
                if (b != (cnt[0] ? CODE_HI : FMT_ADPCM_LO)) begin
                    fail = 1'b1;
                    st   = ST_NOT_ADPCM;
                end else if (cnt[0]) begin
                    cnt_next   = 2'd0;
                    phase_next = PH_CHAN;
                end
            end
            PH_CHAN: begin
                if (b != (cnt[0] ? CODE_HI : CHAN_MONO_LO)) begin
                    fail = 1'b1;
                    st   = ST_NOT_MONO;
                end else if (cnt[0]) begin
                    cnt_next   = 2'd0;
                    phase_next = PH_RATE;
                end
            end
            PH_RATE: begin
                rate_next = {b, rate_reg[31:8]};
                if (s_first_byte) rate_next = {b, 24'd0};
                if (cnt == 2'd3) phase_next = PH_SKIP;
            end
            PH_SKIP: begin
                if (cnt == 2'd3) phase_next = PH_ALIGN;
            end
            PH_ALIGN: begin
                align_next = {b, align_reg[15:8]};
                if (cnt[0]) begin
                    cnt_next   = 2'd0;
                    phase_next = PH_SCANDATA;
                end
            end
            PH_SCANDATA: begin
                cnt_next = cnt;
                if (b == data_byte(mm)) begin
                    match_next = mm + 2'd1;
                    if (mm == 2'd3) phase_next = PH_SIZE;
                end else begin
                    match_next = (b == data_byte(2'd0)) ? 2'd1 : 2'd0;
                end
            end
            PH_SIZE: begin
                size_next = {b, size_reg[31:8]};
                if (cnt == 2'd3) begin
                    fail = 1'b1;
                    st   = ST_OK;
                end
            end
            default: begin
                cnt_next   = cnt;
                phase_next = PH_DONE;
            end
        endcase
        if (fail) begin
            emit = 1'b1;
        end else if (s_last_byte && ph != PH_DONE) begin
            emit = 1'b1;
            if (phase_next <= PH_FMTSIZE) st = ST_BAD_RIFF;
            else if (phase_next == PH_FMTTAG) st = ST_NOT_ADPCM;
            else if (phase_next == PH_CHAN) st = ST_NOT_MONO;
            else st = ST_NO_DATA;
        end
        if (emit) begin
            phase_next = PH_DONE;
            cnt_next   = 2'd0;
            match_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_RIFF;
            cnt_reg     <= 2'd0;
            match_reg   <= 2'd0;
            rate_reg    <= '0;
            align_reg   <= '0;
            size_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                match_reg <= match_next;
                rate_reg  <= rate_next;
                align_reg <= align_next;
                size_reg  <= size_next;
            end
            if (accept && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until taken; zero the fields on a failed parse
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            status_reg    <= st;
            out_rate_reg  <= (st == ST_OK) ? rate_next  : 32'd0;
            out_align_reg <= (st == ST_OK) ? align_next : 16'd0;
            out_size_reg  <= (st == ST_OK) ? size_next  : 32'd0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_sample_rate = out_rate_reg;
    assign m_block_align = out_align_reg;
    assign m_data_size   = out_size_reg;

    a_done_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && emit |=> phase_reg == PH_DONE && cnt_reg == 2'd0 && match_reg == 2'd0)
        else $error("parser not parked after result");

    a_fail_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |->
            m_sample_rate == 32'd0 && m_block_align == 16'd0 && m_data_size == 32'd0)
        else $error("failed result carries nonzero fields");

    a_no_result_when_parked: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && phase_reg == PH_DONE && !s_first_byte |-> !emit)
        else $error("result raised while parked");

    a_valid_only_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(accept && emit) && !(m_valid && !m_ready) |=> !m_valid)
        else $error("result valid without a completing beat");

endmodule
